@@ rtl/tmu_pkg.sv @@
// Shared types, widths, codes and helpers of the triangular matrix unpacker.
package tmu_pkg;

  localparam int POS_W               = 11;
  localparam int OUT_POS_W           = 10;
  localparam int WEIGHT_W            = 31;
  localparam int LAYOUT_W            = 3;
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 11;
  localparam int MAX_CITIES_DEFAULT  = 1024;
  localparam int WEIGHT_BITS_DEFAULT = 31;
  localparam logic [POS_W-1:0] MIN_SIZE = POS_W'(2);

  localparam logic [CFG_INDEX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAYOUT      = 2'd1;

  localparam logic CMD_WEIGHT  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [LAYOUT_W-1:0] {
    LAYOUT_FULL       = 3'd0,
    LAYOUT_UPPER      = 3'd1,
    LAYOUT_LOWER      = 3'd2,
    LAYOUT_UPPER_DIAG = 3'd3,
    LAYOUT_LOWER_DIAG = 3'd4
  } layout_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

  typedef struct packed {
    pos_t pos;
    logic done;
  } step_t;

  function automatic pos_t start_pos(input layout_t lay);
    pos_t p;
    p.row = (lay == LAYOUT_LOWER) ? POS_W'(1) : '0;
    p.col = (lay == LAYOUT_UPPER) ? POS_W'(1) : '0;
    return p;
  endfunction

  function automatic layout_t decode_layout(input logic [LAYOUT_W-1:0] code);
    layout_t lay;
    case (code)
      LAYOUT_UPPER:      lay = LAYOUT_UPPER;
      LAYOUT_LOWER:      lay = LAYOUT_LOWER;
      LAYOUT_UPPER_DIAG: lay = LAYOUT_UPPER_DIAG;
      LAYOUT_LOWER_DIAG: lay = LAYOUT_LOWER_DIAG;
      default:           lay = LAYOUT_FULL;
    endcase
    return lay;
  endfunction

endpackage

@@ rtl/tmu_step.sv @@
// Next packed position and end-of-matrix detection for each layout.
module tmu_step (
  input  tmu_pkg::pos_t               pos,
  input  logic [tmu_pkg::POS_W-1:0]   size,
  input  tmu_pkg::layout_t            layout,
  output tmu_pkg::step_t              step
);
  import tmu_pkg::*;

  localparam int EXT_W = POS_W + 1;

  logic [EXT_W-1:0] r;
  logic [EXT_W-1:0] r1;
  logic [EXT_W-1:0] c1;
  logic [EXT_W-1:0] n;
  logic [EXT_W-1:0] r_new;
  logic [EXT_W-1:0] c_new;
  logic             wrap;
  logic             done;

  always_comb begin
    r     = {1'b0, pos.row};
    r1    = r + EXT_W'(1);
    c1    = {1'b0, pos.col} + EXT_W'(1);
    n     = {1'b0, size};
    r_new = r;
    c_new = c1;
    done  = 1'b0;
    case (layout)
      LAYOUT_UPPER: begin
        wrap = (c1 >= n);
        if (wrap) begin
          r_new = r1;
          c_new = r1 + EXT_W'(1);
          done  = (r1 + EXT_W'(1) >= n);
        end
      end
      LAYOUT_LOWER: begin
        wrap = (c1 >= r);
        if (wrap) begin
          r_new = r1;
          c_new = '0;
          done  = (r1 >= n);
        end
      end
      LAYOUT_UPPER_DIAG: begin
        wrap = (c1 >= n);
        if (wrap) begin
          r_new = r1;
          c_new = r1;
          done  = (r1 >= n);
        end
      end
      LAYOUT_LOWER_DIAG: begin
        wrap = (c1 > r);
        if (wrap) begin
          r_new = r1;
          c_new = '0;
          done  = (r1 >= n);
        end
      end
      default: begin
        wrap = (c1 >= n);
        if (wrap) begin
          r_new = r1;
          c_new = '0;
          done  = (r1 >= n);
        end
      end
    endcase
    step.done = done;
    if (done) begin
      step.pos = pos;
    end else begin
      step.pos.row = r_new[POS_W-1:0];
      step.pos.col = c_new[POS_W-1:0];
    end
  end

endmodule

@@ rtl/triangular_matrix_unpacker_core.sv @@
// Top level of the triangular matrix unpacker: position tracking and write output.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    command, edge_weight
//  out      output     out_valid/out_ready  row_index, col_index, write_weight,
//                                           last_of_run, matrix_complete
//  cfg      input      cfg_write            cfg_index, cfg_data
//
// An input transaction lands in the input register; it is decoded into the write
// register once that register drains; it gives one write in full layout and two
// writes (original write, then mirrored write) in triangular layouts; restarts,
// diagonal positions and dropped weights write nothing.
// An empty input register takes a new transaction while a write waits on out_ready.
// Synchronous reset empties both registers, clears the position and the consumed flag.
// A matrix size or layout write restarts the position at the layout start.
module triangular_matrix_unpacker_core #(
  parameter int MAX_CITIES  = tmu_pkg::MAX_CITIES_DEFAULT,
  parameter int WEIGHT_BITS = tmu_pkg::WEIGHT_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [tmu_pkg::WEIGHT_W-1:0]      edge_weight,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tmu_pkg::OUT_POS_W-1:0]     row_index,
  output logic [tmu_pkg::OUT_POS_W-1:0]     col_index,
  output logic [tmu_pkg::WEIGHT_W-1:0]      write_weight,
  output logic                              last_of_run,
  output logic                              matrix_complete,
  input  logic                              cfg_write,
  input  logic [tmu_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tmu_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tmu_pkg::*;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = (WEIGHT_BITS >= WEIGHT_W) ? '1 :
      WEIGHT_W'((64'(1) << WEIGHT_BITS) - 64'(1));

  logic                s1_valid;
  logic                s1_command;
  logic [WEIGHT_W-1:0] s1_weight;
  logic [1:0]          pend_cnt;
  logic [1:0]          pend_cnt_next;
  logic [POS_W-1:0]    pend_row;
  logic [POS_W-1:0]    pend_col;
  logic [WEIGHT_W-1:0] pend_weight;
  logic                pend_complete;
  logic                pend_load;
  logic                cfg_restart;
  pos_t                pos;
  logic                all_consumed;
  logic [POS_W-1:0]    size;
  layout_t             layout;
  step_t               step;
  logic                s1_advance;
  logic [POS_W-1:0]    size_next;
  layout_t             layout_next;

  tmu_step u_step (
    .pos    (pos),
    .size   (size),
    .layout (layout),
    .step   (step)
  );

  assign s1_advance = s1_valid && ((pend_cnt == 2'd0) || ((pend_cnt == 2'd1) && out_ready));
  assign in_ready   = !s1_valid || s1_advance;
  assign out_valid  = (pend_cnt != 2'd0);

  assign pend_load   = s1_advance && (s1_command == CMD_WEIGHT) && !all_consumed
                       && (pos.row != pos.col);
  assign cfg_restart = cfg_write && ((cfg_index == CFG_MATRIX_SIZE) || (cfg_index == CFG_LAYOUT));

  assign row_index       = OUT_POS_W'(pend_row);
  assign col_index       = OUT_POS_W'(pend_col);
  assign write_weight    = pend_weight;
  assign last_of_run     = (pend_cnt == 2'd1);
  assign matrix_complete = pend_complete;

  always_comb begin
    if (cfg_data < MIN_SIZE) begin
      size_next = MIN_SIZE;
    end else if (int'(cfg_data) > MAX_CITIES) begin
      size_next = POS_W'(MAX_CITIES);
    end else begin
      size_next = cfg_data;
    end
    layout_next = decode_layout(cfg_data[LAYOUT_W-1:0]);
  end

  always_comb begin
    pend_cnt_next = pend_cnt;
    if (pend_load) begin
      pend_cnt_next = (layout == LAYOUT_FULL) ? 2'd1 : 2'd2;
    end else if (out_valid && out_ready) begin
      pend_cnt_next = pend_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      pend_cnt     <= 2'd0;
      pos          <= start_pos(LAYOUT_FULL);
      all_consumed <= 1'b0;
      size         <= MIN_SIZE;
      layout       <= LAYOUT_FULL;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid   <= 1'b1;
        s1_command <= command;
        s1_weight  <= edge_weight & WEIGHT_MASK;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end

      pend_cnt <= pend_cnt_next;

      if (pend_load) begin
        pend_row      <= pos.row;
        pend_col      <= pos.col;
        pend_weight   <= s1_weight;
        pend_complete <= step.done;
      end else if (out_valid && out_ready && (pend_cnt == 2'd2)) begin
        pend_row <= pend_col;
        pend_col <= pend_row;
      end

      if (cfg_write) begin
        case (cfg_index)
          CFG_MATRIX_SIZE: begin
            size <= size_next;
          end
          CFG_LAYOUT: begin
            layout <= layout_next;
          end
          default: begin
          end
        endcase
      end

      if (cfg_restart) begin
        pos          <= start_pos((cfg_index == CFG_LAYOUT) ? layout_next : layout);
        all_consumed <= 1'b0;
      end else if (s1_advance) begin
        if (s1_command == CMD_RESTART) begin
          pos          <= start_pos(layout);
          all_consumed <= 1'b0;
        end else if (!all_consumed) begin
          pos <= step.pos;
          if (step.done) begin
            all_consumed <= 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ rtl/tmu_checker.sv @@
// Port-level assertions of the triangular matrix unpacker and their bind.
module tmu_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tmu_pkg::OUT_POS_W-1:0]     row_index,
  input logic [tmu_pkg::OUT_POS_W-1:0]     col_index,
  input logic [tmu_pkg::WEIGHT_W-1:0]      write_weight,
  input logic                              last_of_run,
  input logic                              matrix_complete
);
  import tmu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_index) && $stable(col_index)
      && $stable(write_weight) && $stable(last_of_run) && $stable(matrix_complete))
    else $error("stalled write changed");

  a_mirror_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid && last_of_run
      && row_index == $past(col_index) && col_index == $past(row_index)
      && write_weight == $past(write_weight) && matrix_complete == $past(matrix_complete))
    else $error("mirrored write missing or wrong");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("write presented right after reset");

  a_input_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with no write pending");

endmodule

bind triangular_matrix_unpacker_core tmu_checker u_tmu_checker (.*);

@@ bench/testbench.sv @@
// Self-checking testbench for the triangular matrix unpacker core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tmu_pkg::*;

  localparam int MAX_N         = MAX_CITIES_DEFAULT;
  localparam int STREAM_TARGET = 700;
  localparam int DRAIN_CYCLES  = 8;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int PRINT_MAX     = 30;

  typedef struct {
    logic                command;
    logic [WEIGHT_W-1:0] weight;
  } stream_item_t;

  typedef struct {
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic [WEIGHT_W-1:0]  weight;
    logic                 last;
    logic                 complete;
  } matrix_write_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   command = CMD_WEIGHT;
  logic [WEIGHT_W-1:0]    edge_weight = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [OUT_POS_W-1:0]   row_index;
  logic [OUT_POS_W-1:0]   col_index;
  logic [WEIGHT_W-1:0]    write_weight;
  logic                   last_of_run;
  logic                   matrix_complete;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_MATRIX_SIZE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  stream_item_t  packed_stream_q[$];
  matrix_write_t matrix_write_q[$];
  stream_item_t  next_item;
  matrix_write_t seen_write;

  // Predictor state
  logic [CFG_DATA_W-1:0] mx_size = CFG_DATA_W'(2);
  logic [LAYOUT_W-1:0]   mx_layout = LAYOUT_FULL;
  int                    row_pos;
  int                    col_pos;
  bit                    consumed;

  bit quiet;
  int gap_left;
  int stall_left;
  int stall_now;
  int idle_cycles;
  int mismatch_count;
  int writes_checked;
  int completions_seen;
  int directed_items;
  int stream_items;
  int phase_count;

  triangular_matrix_unpacker_core u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .edge_weight     (edge_weight),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .row_index       (row_index),
    .col_index       (col_index),
    .write_weight    (write_weight),
    .last_of_run     (last_of_run),
    .matrix_complete (matrix_complete),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int active_size();
    if (mx_size < 2) return 2;
    if (mx_size > MAX_N) return MAX_N;
    return int'(mx_size);
  endfunction

  function automatic layout_t active_layout();
    if (mx_layout > LAYOUT_LOWER_DIAG) return LAYOUT_FULL;
    return layout_t'(mx_layout);
  endfunction

  function automatic void restart_position();
    row_pos  = (active_layout() == LAYOUT_LOWER) ? 1 : 0;
    col_pos  = (active_layout() == LAYOUT_UPPER) ? 1 : 0;
    consumed = 1'b0;
  endfunction

  // Work out the matrix writes caused by one accepted stream transaction.
  function automatic void unpack_weight(input logic cmd, input logic [WEIGHT_W-1:0] w);
    int            n;
    int            r;
    int            c;
    int            cnt;
    bit            done;
    layout_t       lay;
    matrix_write_t wr[2];
    n    = active_size();
    lay  = active_layout();
    cnt  = 0;
    done = 1'b0;
    if (cmd == CMD_RESTART) begin
      restart_position();
      return;
    end
    if (consumed) return;
    r = row_pos;
    c = col_pos;
    if (r != c) begin
      wr[0].row = OUT_POS_W'(r);
      wr[0].col = OUT_POS_W'(c);
      cnt = 1;
      if (lay != LAYOUT_FULL) begin
        wr[1].row = OUT_POS_W'(c);
        wr[1].col = OUT_POS_W'(r);
        cnt = 2;
      end
    end
    c = c + 1;
    case (lay)
      LAYOUT_UPPER: begin
        if (c >= n) begin
          r++;
          c = r + 1;
          done = (r + 1 >= n);
        end
      end
      LAYOUT_LOWER: begin
        if (c >= r) begin
          r++;
          c = 0;
          done = (r >= n);
        end
      end
      LAYOUT_UPPER_DIAG: begin
        if (c >= n) begin
          r++;
          c = r;
          done = (r >= n);
        end
      end
      LAYOUT_LOWER_DIAG: begin
        if (c > r) begin
          r++;
          c = 0;
          done = (r >= n);
        end
      end
      default: begin
        if (c >= n) begin
          r++;
          c = 0;
          done = (r >= n);
        end
      end
    endcase
    if (done) begin
      consumed = 1'b1;
    end else begin
      row_pos = r;
      col_pos = c;
    end
    for (int k = 0; k < cnt; k++) begin
      wr[k].weight   = w;
      wr[k].last     = (k == cnt - 1);
      wr[k].complete = done;
      matrix_write_q = {matrix_write_q, wr[k]};
    end
  endfunction

  function automatic int idle_gap();
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 19);
    if (pick < 10) return 0;
    if (pick < 17) return $urandom_range(1, 3);
    if (pick < 19) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic queue_item(input logic cmd, input logic [WEIGHT_W-1:0] w);
    stream_item_t it;
    it.command = cmd;
    it.weight  = w;
    packed_stream_q = {packed_stream_q, it};
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_MATRIX_SIZE) begin
      mx_size = data;
    end else begin
      mx_layout = data[LAYOUT_W-1:0];
    end
    restart_position();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (packed_stream_q.size() != 0 || in_valid || matrix_write_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One configuration followed by a packed stream for it.
  task automatic run_phase();
    logic [CFG_DATA_W-1:0] size_code;
    logic [LAYOUT_W-1:0]   lay_code;
    int                    n;
    int                    positions;
    int                    total;
    bit                    noisy;
    layout_t               lay;
    case ($urandom_range(0, 15))
      0:       size_code = CFG_DATA_W'(0);
      1:       size_code = CFG_DATA_W'(1);
      2:       size_code = '1;
      3:       size_code = CFG_DATA_W'(MAX_N);
      4:       size_code = CFG_DATA_W'($urandom_range(11, 2046));
      default: size_code = CFG_DATA_W'($urandom_range(2, 9));
    endcase
    lay_code = LAYOUT_W'($urandom_range(0, 7));
    wait_drained();
    quiet = ($urandom_range(0, 4) == 0);
    noisy = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 1) begin
      write_register(CFG_MATRIX_SIZE, size_code);
      write_register(CFG_LAYOUT, CFG_DATA_W'(lay_code));
    end else begin
      write_register(CFG_LAYOUT, CFG_DATA_W'(lay_code));
      write_register(CFG_MATRIX_SIZE, size_code);
    end
    n   = active_size();
    lay = active_layout();
    if (lay == LAYOUT_FULL) positions = n * n;
    else if (lay == LAYOUT_UPPER || lay == LAYOUT_LOWER) positions = n * (n - 1) / 2;
    else positions = n * (n + 1) / 2;
    total = (n > 10) ? $urandom_range(5, 40) : positions;
    for (int i = 0; i < total; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) queue_item(CMD_RESTART, rand_weight());
      else queue_item(CMD_WEIGHT, rand_weight());
      stream_items++;
    end
    repeat ($urandom_range(0, 2)) queue_item(CMD_WEIGHT, rand_weight());
    phase_count++;
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) unpack_weight(command, edge_weight);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (packed_stream_q.size() != 0) begin
          next_item = packed_stream_q.pop_front();
          command     <= next_item.command;
          edge_weight <= next_item.weight;
          in_valid    <= 1'b1;
          gap_left    <= idle_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (matrix_write_q.size() == 0) begin
          report_mismatch($sformatf("unexpected write row %0d col %0d weight %0h",
                                    row_index, col_index, write_weight));
        end else begin
          seen_write = matrix_write_q.pop_front();
          if (row_index !== seen_write.row)
            report_mismatch($sformatf("write %0d row_index %0d, expected %0d",
                                      writes_checked, row_index, seen_write.row));
          if (col_index !== seen_write.col)
            report_mismatch($sformatf("write %0d col_index %0d, expected %0d",
                                      writes_checked, col_index, seen_write.col));
          if (write_weight !== seen_write.weight)
            report_mismatch($sformatf("write %0d write_weight %0h, expected %0h",
                                      writes_checked, write_weight, seen_write.weight));
          if (last_of_run !== seen_write.last)
            report_mismatch($sformatf("write %0d last_of_run %0b, expected %0b",
                                      writes_checked, last_of_run, seen_write.last));
          if (matrix_complete !== seen_write.complete)
            report_mismatch($sformatf("write %0d matrix_complete %0b, expected %0b",
                                      writes_checked, matrix_complete, seen_write.complete));
          if (seen_write.complete && seen_write.last) completions_seen++;
        end
        writes_checked++;
      end
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        stall_now = ($urandom_range(0, 3) == 0) ? idle_gap() : 0;
        if (stall_now > 0) begin
          out_ready  <= 1'b0;
          stall_left <= stall_now - 1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    layout_t tri_layouts[4];
    int      positions;
    tri_layouts = '{LAYOUT_UPPER, LAYOUT_LOWER, LAYOUT_UPPER_DIAG, LAYOUT_LOWER_DIAG};
    restart_position();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: full 2x2, silent diagonal completion, drop and restart
    queue_item(CMD_WEIGHT, '0);
    queue_item(CMD_WEIGHT, '1);
    queue_item(CMD_WEIGHT, WEIGHT_W'(32'h2AAA_AAAA));
    queue_item(CMD_WEIGHT, WEIGHT_W'(32'h5555_5555));
    queue_item(CMD_WEIGHT, rand_weight());
    queue_item(CMD_RESTART, '1);
    queue_item(CMD_WEIGHT, WEIGHT_W'(32'h0135_79BD));
    directed_items = 7;
    foreach (tri_layouts[i]) begin
      wait_drained();
      write_register(CFG_LAYOUT, CFG_DATA_W'(tri_layouts[i]));
      positions = (tri_layouts[i] == LAYOUT_UPPER || tri_layouts[i] == LAYOUT_LOWER) ? 1 : 3;
      repeat (positions + 1) queue_item(CMD_WEIGHT, rand_weight());
      directed_items += positions + 1;
    end

    while (stream_items < STREAM_TARGET) run_phase();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Stream: %0d directed and %0d random transactions over %0d configurations.",
             directed_items, stream_items, phase_count);
    $display("Checked %0d matrix writes, %0d completed matrices, %0d mismatches.",
             writes_checked, completions_seen, mismatch_count);
    if (mismatch_count == 0 && matrix_write_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ triangular_matrix_unpacker_core.f @@
rtl/tmu_pkg.sv
rtl/tmu_step.sv
rtl/triangular_matrix_unpacker_core.sv
rtl/tmu_checker.sv
bench/testbench.sv
